>>> sv/cse_pkg.sv
package cse_pkg;

	localparam int CFG_BITS       = 5;
	localparam int CRANE_IN_BITS  = 4;
	localparam int PROC_BITS      = 16;
	localparam int OUT_TIME_BITS  = 40;
	localparam int IDLE_BITS      = 44;
	localparam int RESET_CRANES   = 2;

	localparam logic [IDLE_BITS-1:0] IDLE_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_APPLY,
		ST_DIFF,
		ST_INJECT,
		ST_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic apply;
		logic push;
	} ctrl_t;

	typedef struct packed {
		logic                 valid;
		logic                 clash;
		logic [IDLE_BITS-1:0] acc;
	} link_t;

endpackage

>>> sv/cse_intf.sv
interface cse_job_if;
	import cse_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     new_schedule;
	logic [CRANE_IN_BITS-1:0] crane;
	logic [PROC_BITS-1:0]     proc_time;

	modport source (output valid, new_schedule, crane, proc_time, input ready);
	modport sink (input valid, new_schedule, crane, proc_time, output ready);
endinterface

interface cse_res_if;
	import cse_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OUT_TIME_BITS-1:0] start_time;
	logic [OUT_TIME_BITS-1:0] finish_time;
	logic [OUT_TIME_BITS-1:0] makespan;
	logic [IDLE_BITS-1:0]     idle_total;
	logic                     clash;
	logic                     feasible;

	modport source (output valid, start_time, finish_time, makespan, idle_total, clash,
		feasible, input ready);
	modport sink (input valid, start_time, finish_time, makespan, idle_total, clash,
		feasible, output ready);
endinterface

interface cse_cfg_if;
	import cse_pkg::*;

	logic                valid;
	logic                ready;
	logic [CFG_BITS-1:0] num_cranes;

	modport source (output valid, num_cranes, input ready);
	modport sink (input valid, num_cranes, output ready);
endinterface

>>> sv/cse_cell.sv
module cse_cell #(
	parameter int TIME_BITS  = 40,
	parameter int MAX_CRANES = 16,
	parameter int INDEX      = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cse_pkg::ctrl_t                       ctrl,
	input  logic [$clog2(MAX_CRANES)-1:0]        crane,
	input  logic [$clog2(MAX_CRANES+1)-1:0]      num_cranes,
	input  logic [$clog2(MAX_CRANES)-1:0]        recent_count,
	input  logic [TIME_BITS-1:0]                 start_time,
	input  logic [TIME_BITS-1:0]                 finish_time,
	input  logic [TIME_BITS-1:0]                 ready_lead,
	output logic [TIME_BITS-1:0]                 ready,
	input  logic [TIME_BITS-1:0]                 hist_start_in,
	input  logic [TIME_BITS-1:0]                 hist_finish_in,
	input  logic [$clog2(MAX_CRANES)-1:0]        hist_crane_in,
	output logic [TIME_BITS-1:0]                 hist_start_out,
	output logic [TIME_BITS-1:0]                 hist_finish_out,
	output logic [$clog2(MAX_CRANES)-1:0]        hist_crane_out,
	input  cse_pkg::link_t                       link_in,
	output cse_pkg::link_t                       link_out
);
	import cse_pkg::*;

	localparam int CW = $clog2(MAX_CRANES);
	localparam int MW = $clog2(MAX_CRANES + 1);
	localparam int IW = MW + 1;
	localparam int SW = ((TIME_BITS > IDLE_BITS) ? TIME_BITS : IDLE_BITS) + 1;

	logic [TIME_BITS-1:0] ready_q;
	logic [TIME_BITS-1:0] diff_q;
	logic [TIME_BITS-1:0] hist_start_q;
	logic [TIME_BITS-1:0] hist_finish_q;
	logic [CW-1:0]        hist_crane_q;
	link_t                link_q;

	logic          index_ok;
	logic          overlap;
	logic [SW-1:0] acc_sum;
	link_t         link_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= '0;
		end else if (ctrl.clear) begin
			ready_q <= '0;
		end else if (ctrl.apply) begin
			if (IW'(crane) == IW'(INDEX)) begin
				ready_q <= finish_time;
			end else if (IW'(INDEX) < IW'(crane) && ready_q < finish_time) begin
				ready_q <= finish_time;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (IW'(INDEX) < IW'(num_cranes) && ready_lead >= ready_q) begin
			diff_q <= ready_lead - ready_q;
		end else begin
			diff_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			hist_start_q  <= hist_start_in;
			hist_finish_q <= hist_finish_in;
			hist_crane_q  <= hist_crane_in;
		end
	end

	// This cell checks the container INDEX + 1 places back in the history.
	always_comb begin
		index_ok = (IW'(INDEX + 3) <= IW'(num_cranes))
			&& (IW'(INDEX + 2) <= IW'(crane))
			&& (IW'(INDEX + 1) <= IW'(recent_count))
			&& (IW'(hist_crane_q) < IW'(crane))
			&& (IW'(crane) > IW'(hist_crane_q) + IW'(INDEX + 1));
		overlap = (start_time < hist_finish_q) && (hist_start_q < finish_time)
			&& (start_time < finish_time) && (hist_start_q < hist_finish_q);
		acc_sum = SW'(link_in.acc) + SW'(diff_q);
		link_d.valid = link_in.valid;
		link_d.clash = link_in.clash | (index_ok & overlap);
		link_d.acc = (acc_sum > SW'(IDLE_MAX)) ? IDLE_MAX : acc_sum[IDLE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q <= link_d;
		end
	end

	assign ready           = ready_q;
	assign hist_start_out  = hist_start_q;
	assign hist_finish_out = hist_finish_q;
	assign hist_crane_out  = hist_crane_q;
	assign link_out        = link_q;

endmodule

>>> sv/crane_schedule_evaluator_unit.sv
// Channel  Role    Payload
// job      sink    new_schedule, crane, proc_time
// result   source  start_time, finish_time, makespan, idle_total, clash, feasible
// cfg      sink    num_cranes (always ready)
//
// One item goes from acceptance to a loaded result register while the idle-time and clash
// token walks the crane cells one cell a cycle; no new item is accepted before the last is
// done. The job channel is ready only while no item is in flight; a finished result waits
// in the output register while the next item is worked on, and a stalled result channel
// holds the following item in the done state until the result is taken. Reset clears crane
// times and history count, sets feasibility and two cranes.
module crane_schedule_evaluator_unit #(
	parameter int MAX_CRANES = 16,
	parameter int TIME_BITS  = 40
) (
	input logic      clk,
	input logic      arst_n,
	cse_job_if.sink  job,
	cse_res_if.source result,
	cse_cfg_if.sink  cfg
);
	import cse_pkg::*;

	localparam int CW         = $clog2(MAX_CRANES);
	localparam int MW         = $clog2(MAX_CRANES + 1);
	localparam int NW         = $clog2(MAX_CRANES);
	localparam int MXW        = (MW > CFG_BITS) ? MW : CFG_BITS;
	localparam int HIST_DEPTH = MAX_CRANES - 2;

	state_t state_q;
	state_t state_d;
	ctrl_t  ctrl;
	logic   inject;
	logic   job_accept;
	logic   load;

	logic [MW-1:0]        m_q;
	logic [CW-1:0]        c_q;
	logic [PROC_BITS-1:0] p_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] finish_q;
	logic [NW-1:0]        rc_q;
	logic                 feas_q;
	logic [IDLE_BITS-1:0] idle_q;
	logic                 clash_q;

	logic                     out_vq;
	logic [OUT_TIME_BITS-1:0] start_time_q;
	logic [OUT_TIME_BITS-1:0] finish_time_q;
	logic [OUT_TIME_BITS-1:0] makespan_q;
	logic [IDLE_BITS-1:0]     idle_total_q;
	logic                     clash_out_q;
	logic                     feasible_q;

	logic [MXW-1:0]       cfg_raw;
	logic [MXW-1:0]       crane_raw;
	logic [MXW-1:0]       crane_lim;
	logic [TIME_BITS-1:0] start_w;
	logic [TIME_BITS:0]   fin_sum;
	logic                 feas_next;

	logic [TIME_BITS-1:0] ready_w [MAX_CRANES];
	logic [TIME_BITS-1:0] hs_w    [MAX_CRANES+1];
	logic [TIME_BITS-1:0] hf_w    [MAX_CRANES+1];
	logic [CW-1:0]        hc_w    [MAX_CRANES+1];
	link_t                links   [MAX_CRANES+1];

	assign job_accept = job.valid && job.ready;
	assign load = (state_q == ST_DONE) && (!out_vq || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		job.ready = 1'b0;
		inject = 1'b0;
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				job.ready = 1'b1;
				ctrl.clear = job.valid && job.new_schedule;
				if (job.valid) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: state_d = ST_APPLY;
			ST_APPLY: begin
				ctrl.apply = 1'b1;
				state_d = ST_DIFF;
			end
			ST_DIFF: state_d = ST_INJECT;
			ST_INJECT: begin
				inject = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (links[MAX_CRANES].valid) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				ctrl.push = load;
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign cfg.ready = 1'b1;
	assign cfg_raw = MXW'(cfg.num_cranes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= MW'(RESET_CRANES);
		end else if (cfg.valid && cfg.ready) begin
			if (cfg_raw == '0) begin
				m_q <= MW'(1);
			end else if (cfg_raw > MXW'(MAX_CRANES)) begin
				m_q <= MW'(MAX_CRANES);
			end else begin
				m_q <= MW'(cfg_raw);
			end
		end
	end

	assign crane_raw = MXW'(job.crane);
	assign crane_lim = MXW'(m_q) - MXW'(1);
	assign start_w = ready_w[c_q];
	assign fin_sum = (TIME_BITS+1)'(start_w) + (TIME_BITS+1)'(p_q);
	assign feas_next = feas_q & ~clash_q;

	always_ff @(posedge clk) begin
		if (job_accept) begin
			c_q <= CW'((crane_raw > crane_lim) ? crane_lim : crane_raw);
			p_q <= job.proc_time;
		end
		if (state_q == ST_CALC) begin
			start_q <= start_w;
			finish_q <= fin_sum[TIME_BITS] ? '1 : fin_sum[TIME_BITS-1:0];
		end
		if (state_q == ST_WAIT && links[MAX_CRANES].valid) begin
			idle_q <= links[MAX_CRANES].acc;
			clash_q <= links[MAX_CRANES].clash;
		end
		if (load) begin
			start_time_q <= OUT_TIME_BITS'(start_q);
			finish_time_q <= OUT_TIME_BITS'(finish_q);
			makespan_q <= OUT_TIME_BITS'(ready_w[0]);
			idle_total_q <= idle_q;
			clash_out_q <= clash_q;
			feasible_q <= feas_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
			feas_q <= 1'b1;
			out_vq <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				rc_q <= '0;
				feas_q <= 1'b1;
			end else if (ctrl.push) begin
				if (rc_q < NW'(HIST_DEPTH)) begin
					rc_q <= rc_q + NW'(1);
				end
				feas_q <= feas_next;
			end
			if (load) begin
				out_vq <= 1'b1;
			end else if (result.ready) begin
				out_vq <= 1'b0;
			end
		end
	end

	assign result.valid       = out_vq;
	assign result.start_time  = start_time_q;
	assign result.finish_time = finish_time_q;
	assign result.makespan    = makespan_q;
	assign result.idle_total  = idle_total_q;
	assign result.clash       = clash_out_q;
	assign result.feasible    = feasible_q;

	assign hs_w[0] = start_q;
	assign hf_w[0] = finish_q;
	assign hc_w[0] = c_q;
	assign links[0] = '{valid: inject, clash: 1'b0, acc: '0};

	for (genvar k = 0; k < MAX_CRANES; k++) begin : g_cell
		cse_cell #(
			.TIME_BITS (TIME_BITS),
			.MAX_CRANES(MAX_CRANES),
			.INDEX     (k)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctrl           (ctrl),
			.crane          (c_q),
			.num_cranes     (m_q),
			.recent_count   (rc_q),
			.start_time     (start_q),
			.finish_time    (finish_q),
			.ready_lead     (ready_w[0]),
			.ready          (ready_w[k]),
			.hist_start_in  (hs_w[k]),
			.hist_finish_in (hf_w[k]),
			.hist_crane_in  (hc_w[k]),
			.hist_start_out (hs_w[k+1]),
			.hist_finish_out(hf_w[k+1]),
			.hist_crane_out (hc_w[k+1]),
			.link_in        (links[k]),
			.link_out       (links[k+1])
		);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		inject |-> ##MAX_CRANES links[MAX_CRANES].valid)
		else $error("Token did not leave the cell chain on time.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |=> (ready_w[0] >= finish_q))
		else $error("Leftmost crane is behind the finish time just applied.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!feas_q && !ctrl.clear) |=> !feas_q)
		else $error("Feasibility came back without a new schedule.");

endmodule
